// ===== rtl/larc_pkg.sv =====
// ----------------------------------------------------------------------------
// larc_pkg
// Shared types and constants of the lazy adaptive cache policy core.
// ----------------------------------------------------------------------------
package larc_pkg;

    localparam int unsigned TAG_W   = 32;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned RUN_W   = 7;
    localparam int unsigned CAP_W   = 6;
    localparam int unsigned OUT_W   = 2;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 6'd30;

    typedef enum logic [1:0] {
        OUT_REG_HIT   = 2'd0,
        OUT_GHOST_HIT = 2'd1,
        OUT_MISS      = 2'd2,
        OUT_BAD_TYPE  = 2'd3
    } outcome_t;

    typedef enum logic [0:0] {
        REG_REGULAR_CAP = 1'b0,
        REG_GHOST_CAP   = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_RTRIM,
        ST_GTRIM,
        ST_POST,
        ST_SHOW
    } state_t;

    // Command broadcast along a chain of cells.
    typedef struct packed {
        logic             hit_touch;  // move the matching entry to most recent
        logic             hit_drop;   // drop the matching entry
        logic             insert;     // age all and insert tag at rank zero
        logic             evict;      // drop the entry at rank evict_rank
        logic [10:0]      evict_rank;
    } cell_cmd_t;

endpackage

// ===== rtl/larc_cell.sv =====
// ----------------------------------------------------------------------------
// larc_cell
// One entry of a recency list: tag, valid bit and recency rank. It matches the
// broadcast tag, ages its rank and takes an insert handed on from its left
// neighbour when it is the first free entry.
// ----------------------------------------------------------------------------
module larc_cell #(
    parameter int unsigned RANK_W = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [larc_pkg::TAG_W-1:0]    tag,
    input  larc_pkg::cell_cmd_t           cmd,
    input  logic [RANK_W-1:0]             hit_rank,
    input  logic                          free_in,
    output logic                          free_out,
    output logic                          match,
    output logic [RANK_W-1:0]             rank
);

    logic [larc_pkg::TAG_W-1:0] tag_reg;
    logic [RANK_W-1:0]          rank_reg, rank_next;
    logic                       valid_reg, valid_next;
    logic                       take;
    logic                       gone;

    assign match    = valid_reg && (tag_reg == tag);
    assign rank     = rank_reg;
    assign take     = cmd.insert && !valid_reg && !free_in;
    assign free_out = free_in || !valid_reg;
    assign gone     = valid_reg && ((cmd.hit_drop && match) ||
                      (cmd.evict && (11'(rank_reg) == cmd.evict_rank)));

    always_comb
    begin
        rank_next  = rank_reg;
        valid_next = valid_reg;
        if (cmd.hit_touch && valid_reg)
        begin
            if (match)
                rank_next = '0;
            else if (rank_reg < hit_rank)
                rank_next = rank_reg + 1'b1;
        end
        if (cmd.hit_drop && valid_reg && !match && rank_reg > hit_rank)
            rank_next = rank_reg - 1'b1;
        if (cmd.evict && valid_reg && 11'(rank_reg) > cmd.evict_rank)
            rank_next = rank_reg - 1'b1;
        if (gone)
        begin
            valid_next = 1'b0;
            rank_next  = '0;
        end
        if (cmd.insert)
        begin
            if (valid_reg)
                rank_next = rank_reg + 1'b1;
            else if (take)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            tag_reg <= tag;
    end

endmodule

// ===== rtl/larc_list.sv =====
// ----------------------------------------------------------------------------
// larc_list
// A recency list built as a row of cells with a free-slot chain running
// through it, and its occupancy count.
// ----------------------------------------------------------------------------
module larc_list #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [larc_pkg::TAG_W-1:0]    tag,
    input  larc_pkg::cell_cmd_t           cmd,
    output logic                          hit,
    output logic [10:0]                   occ
);

    localparam int unsigned RANK_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH:0]        free_chain;
    logic [DEPTH-1:0]      match_vec;
    logic [RANK_W-1:0]     rank_arr [DEPTH];
    logic [RANK_W-1:0]     hit_rank;
    logic [10:0]           occ_reg, occ_next;

    assign free_chain[0] = 1'b0;
    assign hit = |match_vec;
    assign occ = occ_reg;

    always_comb
    begin
        hit_rank = '0;
        for (int i = 0; i < DEPTH; i++)
            if (match_vec[i])
                hit_rank = hit_rank | rank_arr[i];
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        larc_cell #(.RANK_W(RANK_W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tag      (tag),
            .cmd      (cmd),
            .hit_rank (hit_rank),
            .free_in  (free_chain[g]),
            .free_out (free_chain[g+1]),
            .match    (match_vec[g]),
            .rank     (rank_arr[g])
        );
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.hit_drop && hit)
            occ_next = occ_next - 1'b1;
        if (cmd.evict && occ_reg != '0)
            occ_next = occ_next - 1'b1;
        if (cmd.insert && free_chain[DEPTH])
            occ_next = occ_next + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

endmodule

// ===== rtl/lazy_adaptive_cache_policy_core.sv =====
// ----------------------------------------------------------------------------
// lazy_adaptive_cache_policy_core
// Lazy adaptive replacement policy over a regular and a ghost recency list.
// ----------------------------------------------------------------------------
// Each block is looked up in both lists (ST_LOOK) and then offers its word: a
// regular hit in the next cycle, a ghost hit or miss after an insert and a ghost
// trim (ST_RTRIM or ST_GTRIM, then ST_POST), with an eviction step per eviction.
// A new request is taken only when idle, the cycle after the last word goes.
// A wrong-type request offers its single word in the cycle after acceptance.
// Reset empties both lists, clears the hit counters and sets capacities to 30.
module lazy_adaptive_cache_policy_core #(
    parameter int unsigned REGULAR_DEPTH = 32,
    parameter int unsigned GHOST_DEPTH   = 32,
    parameter int unsigned MAX_RUN       = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] start_block,
    input  logic [6:0]  block_count,
    input  logic        mode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  outcome,
    output logic [31:0] block_number,
    output logic        last,
    output logic [5:0]  regular_count,
    output logic [5:0]  ghost_count,
    output logic [31:0] regular_hits,
    output logic [31:0] ghost_hits
);

    larc_pkg::state_t    seq_reg, seq_next;
    logic [5:0]          rcap_reg, gcap_reg;
    logic [31:0]         cur_blk_reg, cur_blk_next;
    logic [6:0]          left_reg, left_next;
    logic                bad_reg, bad_next;
    logic [1:0]          oc_reg, oc_next;
    logic [31:0]         rhits_reg, rhits_next, ghits_reg, ghits_next;
    logic                rhit, ghit;
    logic [10:0]         rocc, gocc, rcap, gcap;
    larc_pkg::cell_cmd_t rcmd, gcmd;
    logic [6:0]          cnt_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcap_reg <= larc_pkg::CAPACITY_RESET;
            gcap_reg <= larc_pkg::CAPACITY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                larc_pkg::REG_REGULAR_CAP: rcap_reg <= cfg_data;
                larc_pkg::REG_GHOST_CAP:   gcap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rcap = (rcap_reg == '0) ? 11'd1 : 11'(rcap_reg);
        if (rcap > 11'(REGULAR_DEPTH))
            rcap = 11'(REGULAR_DEPTH);
        gcap = (gcap_reg == '0) ? 11'd1 : 11'(gcap_reg);
        if (gcap > 11'(GHOST_DEPTH))
            gcap = 11'(GHOST_DEPTH);
    end

    larc_list #(.DEPTH(REGULAR_DEPTH)) u_regular (
        .clk(clk), .rst_n(rst_n), .tag(cur_blk_reg), .cmd(rcmd), .hit(rhit), .occ(rocc)
    );
    larc_list #(.DEPTH(GHOST_DEPTH)) u_ghost (
        .clk(clk), .rst_n(rst_n), .tag(cur_blk_reg), .cmd(gcmd), .hit(ghit), .occ(gocc)
    );

    assign cnt_sat = (block_count > 7'(MAX_RUN)) ? 7'(MAX_RUN) : block_count;

    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            larc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode)
                        seq_next = larc_pkg::ST_SHOW;
                    else if (cnt_sat != '0)
                        seq_next = larc_pkg::ST_LOOK;
                end
            end
            larc_pkg::ST_LOOK:
            begin
                if (rhit)
                    seq_next = larc_pkg::ST_SHOW;
                else if (ghit)
                    seq_next = larc_pkg::ST_RTRIM;
                else
                    seq_next = larc_pkg::ST_GTRIM;
            end
            larc_pkg::ST_RTRIM:
            begin
                if (!(rocc > rcap - 1'b1))
                    seq_next = larc_pkg::ST_POST;
            end
            larc_pkg::ST_GTRIM:
            begin
                if (!(gocc > gcap - 1'b1))
                    seq_next = larc_pkg::ST_POST;
            end
            larc_pkg::ST_POST:
            begin
                if (!(gocc > gcap))
                    seq_next = larc_pkg::ST_SHOW;
            end
            larc_pkg::ST_SHOW:
            begin
                if (out_ready)
                begin
                    if (bad_reg || left_reg <= 7'd1)
                        seq_next = larc_pkg::ST_IDLE;
                    else
                        seq_next = larc_pkg::ST_LOOK;
                end
            end
            default: seq_next = larc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cur_blk_next = cur_blk_reg;
        left_next    = left_reg;
        bad_next     = bad_reg;
        oc_next      = oc_reg;
        rhits_next   = rhits_reg;
        ghits_next   = ghits_reg;
        rcmd         = '0;
        gcmd         = '0;
        unique case (seq_reg)
            larc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_blk_next = start_block;
                    left_next    = cnt_sat;
                    bad_next     = mode;
                    oc_next      = larc_pkg::OUT_BAD_TYPE;
                end
            end
            larc_pkg::ST_LOOK:
            begin
                if (rhit)
                begin
                    rcmd.hit_touch = 1'b1;
                    rhits_next     = rhits_reg + 1'b1;
                    oc_next        = larc_pkg::OUT_REG_HIT;
                end
                else if (ghit)
                begin
                    gcmd.hit_drop = 1'b1;
                    ghits_next    = ghits_reg + 1'b1;
                    oc_next       = larc_pkg::OUT_GHOST_HIT;
                end
                else
                    oc_next = larc_pkg::OUT_MISS;
            end
            larc_pkg::ST_RTRIM:
            begin
                if (rocc > rcap - 1'b1)
                begin
                    rcmd.evict      = 1'b1;
                    rcmd.evict_rank = rocc - 1'b1;
                end
                else
                    rcmd.insert = 1'b1;
            end
            larc_pkg::ST_GTRIM:
            begin
                if (gocc > gcap - 1'b1)
                begin
                    gcmd.evict      = 1'b1;
                    gcmd.evict_rank = gocc - 1'b1;
                end
                else
                    gcmd.insert = 1'b1;
            end
            larc_pkg::ST_POST:
            begin
                if (gocc > gcap)
                begin
                    gcmd.evict      = 1'b1;
                    gcmd.evict_rank = gocc - 1'b1;
                end
            end
            larc_pkg::ST_SHOW:
            begin
                if (out_ready && !(bad_reg || left_reg <= 7'd1))
                begin
                    left_next    = left_reg - 1'b1;
                    cur_blk_next = cur_blk_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= larc_pkg::ST_IDLE;
            rhits_reg <= '0;
            ghits_reg <= '0;
            left_reg  <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            seq_reg   <= seq_next;
            rhits_reg <= rhits_next;
            ghits_reg <= ghits_next;
            left_reg  <= left_next;
            bad_reg   <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_blk_reg <= cur_blk_next;
        oc_reg      <= oc_next;
    end

    assign in_ready      = (seq_reg == larc_pkg::ST_IDLE);
    assign out_valid     = (seq_reg == larc_pkg::ST_SHOW);
    assign outcome       = oc_reg;
    assign block_number  = cur_blk_reg;
    assign last          = bad_reg || (left_reg <= 7'd1);
    assign regular_count = rocc[5:0];
    assign ghost_count   = gocc[5:0];
    assign regular_hits  = rhits_reg;
    assign ghost_hits    = ghits_reg;

endmodule
